### hdl/dphm_pkg.sv
`timescale 1ns / 1ps

package dphm_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_X       = 3'd0;
    localparam logic [2:0] REG_COEF_Y       = 3'd1;
    localparam logic [2:0] REG_COEF_CONST   = 3'd2;
    localparam logic [2:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [2:0] REG_RAW_SCALE    = 3'd4;
    localparam logic [2:0] REG_MIN_DEPTH    = 3'd5;
    localparam logic [2:0] REG_HEIGHT_THR   = 3'd6;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // reset values
    localparam logic signed [31:0] RST_COEF_X       = 32'sd0;
    localparam logic signed [31:0] RST_COEF_Y       = 32'sd0;
    localparam logic signed [31:0] RST_COEF_CONST   = 32'sd16777216;
    localparam logic signed [23:0] RST_PLANE_OFFSET = 24'sd0;
    localparam logic [15:0]        RST_RAW_SCALE    = 16'd256;
    localparam logic [15:0]        RST_MIN_DEPTH    = 16'd100;
    localparam logic [23:0]        RST_HEIGHT_THR   = 24'd50;

    // fixed point: coefficient fraction bits
    localparam int FRAC_BITS = 24;

    typedef struct packed {
        logic signed [31:0] coef_x;
        logic signed [31:0] coef_y;
        logic signed [31:0] coef_const;
        logic signed [23:0] plane_offset;
        logic [15:0]        raw_scale;
        logic [15:0]        min_depth;
        logic [23:0]        height_threshold;
    } t_cfg;

endpackage

### hdl/dphm_cfg_regs.sv
`timescale 1ns / 1ps

module dphm_cfg_regs
    import dphm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode one write word into the register file
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_X:       n_cfg.coef_x           = $signed(i_cfg_data);
                REG_COEF_Y:       n_cfg.coef_y           = $signed(i_cfg_data);
                REG_COEF_CONST:   n_cfg.coef_const       = $signed(i_cfg_data);
                REG_PLANE_OFFSET: n_cfg.plane_offset     = $signed(i_cfg_data[23:0]);
                REG_RAW_SCALE:    n_cfg.raw_scale        = i_cfg_data[15:0];
                REG_MIN_DEPTH:    n_cfg.min_depth        = i_cfg_data[15:0];
                REG_HEIGHT_THR:   n_cfg.height_threshold = i_cfg_data[23:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_x           <= RST_COEF_X;
            r_cfg.coef_y           <= RST_COEF_Y;
            r_cfg.coef_const       <= RST_COEF_CONST;
            r_cfg.plane_offset     <= RST_PLANE_OFFSET;
            r_cfg.raw_scale        <= RST_RAW_SCALE;
            r_cfg.min_depth        <= RST_MIN_DEPTH;
            r_cfg.height_threshold <= RST_HEIGHT_THR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/depth_plane_height_mask_top.sv
`timescale 1ns / 1ps

// depth pixel height above a ground plane, with obstacle flag
// input channel: i_valid / o_ready carrying raw depth, column and row of one pixel
// output channel: o_valid / i_ready carrying height in mm, obstacle and depth valid
// config channel: i_cfg_valid / o_cfg_ready with register index and 32-bit data;
//   always ready, write only while no pixel is in flight
// pipeline: five register stages (input products, depth saturate and
//   coefficient sum, split plane product, offset add, abs/saturate/threshold)
// throughput: one pixel per clock, sustained while the receiver is ready
// a stall of the receiver freezes the whole pipeline; o_ready drops in the same
//   cycle so no word is lost or repeated; empty stages are not filled while
//   stalled, since every stage advances on the same enable
// reset: synchronous active low, clears all stage valid bits and loads the
//   configuration defaults (unit scale, min depth 100, threshold 50)
// pixels at or below the minimum depth come out with height 0, no obstacle
//   and depth valid low
module depth_plane_height_mask_top
    import dphm_pkg::*;
#(
    parameter int COORD_WIDTH = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // pixel input
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [15:0]                i_depth_raw,
    input  logic [COORD_WIDTH-1:0]     i_pixel_col,
    input  logic [COORD_WIDTH-1:0]     i_pixel_row,
    // result output
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [23:0]                o_height_mm,
    output logic                       o_obstacle,
    output logic                       o_depth_valid,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    // datapath widths
    localparam int PXW = 32 + COORD_WIDTH + 1;       // coef * coordinate
    localparam int SW  = PXW + 2;                    // coefficient sum
    localparam int SHW = SW - FRAC_BITS;             // integer part of sum
    localparam int PLW = 16 + FRAC_BITS;             // depth * fraction
    localparam int PHW = 17 + SHW;                   // depth * integer part
    localparam int HW  = PHW + 1;                    // height before abs
    localparam int NST = 5;

    t_cfg w_cfg;

    dphm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    // pipeline advance
    logic           w_adv;
    logic [NST-1:0] r_vld;

    assign w_adv   = !r_vld[NST-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 1: depth scale and coordinate products
    logic [31:0]           r_dprod;
    logic signed [PXW-1:0] r_px;
    logic signed [PXW-1:0] r_py;
    logic signed [PXW-1:0] n_px;
    logic signed [PXW-1:0] n_py;

    assign n_px = w_cfg.coef_x * $signed({1'b0, i_pixel_col});
    assign n_py = w_cfg.coef_y * $signed({1'b0, i_pixel_row});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dprod <= i_depth_raw * w_cfg.raw_scale;
            r_px    <= n_px;
            r_py    <= n_py;
        end
    end

    // stage 2: depth saturate, valid check, coefficient sum
    logic [15:0]          n_dmm;
    logic signed [SW-1:0] n_s;
    logic [15:0]          r_dmm;
    logic                 r_dv2;
    logic signed [SW-1:0] r_s;

    assign n_dmm = (|r_dprod[31:24]) ? 16'hFFFF : r_dprod[23:8];
    assign n_s   = SW'(r_px) + SW'(r_py) + SW'(w_cfg.coef_const);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dmm <= n_dmm;
            r_dv2 <= (n_dmm > w_cfg.min_depth);
            r_s   <= n_s;
        end
    end

    // stage 3: depth times integer and fraction parts of the sum
    logic signed [SHW-1:0] w_shi;
    logic [FRAC_BITS-1:0]  w_slo;
    logic [PLW-1:0]        r_plo;
    logic signed [PHW-1:0] r_phi;
    logic                  r_dv3;

    assign w_shi = r_s[SW-1:FRAC_BITS];
    assign w_slo = r_s[FRAC_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_plo <= r_dmm * w_slo;
            r_phi <= $signed({1'b0, r_dmm}) * w_shi;
            r_dv3 <= r_dv2;
        end
    end

    // stage 4: floor of product plus plane offset
    logic signed [HW-1:0] n_h;
    logic signed [HW-1:0] r_h;
    logic                 r_dv4;

    assign n_h = HW'(r_phi) + HW'($signed({1'b0, r_plo[PLW-1:FRAC_BITS]}))
               + HW'(w_cfg.plane_offset);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h   <= n_h;
            r_dv4 <= r_dv3;
        end
    end

    // stage 5: abs, saturate, threshold compare
    logic [HW-1:0] w_mag;
    logic [23:0]   w_hsat;
    logic [23:0]   r_height;
    logic          r_obst;
    logic          r_dvalid;

    assign w_mag  = r_h[HW-1] ? HW'(-r_h) : HW'(r_h);
    assign w_hsat = (|w_mag[HW-1:24]) ? 24'hFFFFFF : w_mag[23:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_height <= r_dv4 ? w_hsat : 24'd0;
            r_obst   <= r_dv4 && (w_hsat > w_cfg.height_threshold);
            r_dvalid <= r_dv4;
        end
    end

    assign o_height_mm   = r_height;
    assign o_obstacle    = r_obst;
    assign o_depth_valid = r_dvalid;

    // checks
    a_obst_needs_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_obstacle |-> o_depth_valid)
        else $error("obstacle flagged on an invalid depth word");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_depth_valid |-> o_height_mm == 24'd0)
        else $error("invalid depth word with nonzero height");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_vld))
        else $error("pipeline moved during an output stall");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import dphm_pkg::*;

    localparam int COORD_W          = 12;
    localparam int PIPE_LATENCY     = 5;
    localparam int STALL_LIMIT      = 2000;
    localparam int PHASES           = 8;
    localparam int PIXELS_PER_PHASE = 120;
    // index with no register behind it, writes must be dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [23:0] height_mm;
        logic        obstacle;
        logic        depth_valid;
    } t_height_word;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [15:0]                i_depth_raw;
    logic [COORD_W-1:0]         i_pixel_col;
    logic [COORD_W-1:0]         i_pixel_row;
    logic                       o_valid;
    logic                       i_ready;
    logic [23:0]                o_height_mm;
    logic                       o_obstacle;
    logic                       o_depth_valid;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    t_cfg         plane_cfg;
    t_height_word height_q[$];
    t_height_word expected_word;
    int           mismatches;
    int           pixels_sent;
    int           words_checked;
    int           settings_applied;
    int           idle_count;
    int           ready_hold;
    bit           idle_enable;

    depth_plane_height_mask_top #(
        .COORD_WIDTH(COORD_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_depth_raw  (i_depth_raw),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_height_mm  (o_height_mm),
        .o_obstacle   (o_obstacle),
        .o_depth_valid(o_depth_valid),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // expected height word for one pixel under a given plane setting
    function automatic t_height_word predict_height(t_cfg cfg, logic [15:0] raw,
                                                    logic [COORD_W-1:0] col,
                                                    logic [COORD_W-1:0] row);
        logic [31:0]        scaled;
        logic [15:0]        depth_mm;
        logic signed [79:0] kx, ky, k0, ofs, coef_sum, h;
        t_height_word       w;
        w = '0;
        scaled = (32'(raw) * 32'(cfg.raw_scale)) >> 8;
        depth_mm = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
        if (depth_mm <= cfg.min_depth)
            return w;
        kx  = $signed(cfg.coef_x);
        ky  = $signed(cfg.coef_y);
        k0  = $signed(cfg.coef_const);
        ofs = $signed(cfg.plane_offset);
        coef_sum = kx * $signed({68'd0, col}) + ky * $signed({68'd0, row}) + k0;
        // arithmetic shift floors toward minus infinity
        h = ((coef_sum * $signed({64'd0, depth_mm})) >>> FRAC_BITS) + ofs;
        if (h < 0)
            h = -h;
        w.height_mm   = (h > 80'sd16777215) ? 24'hFFFFFF : h[23:0];
        w.obstacle    = w.height_mm > cfg.height_threshold;
        w.depth_valid = 1'b1;
        return w;
    endfunction

    // shadow copy of the register file
    function automatic void store_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
        case (idx)
            REG_COEF_X:       plane_cfg.coef_x           = data;
            REG_COEF_Y:       plane_cfg.coef_y           = data;
            REG_COEF_CONST:   plane_cfg.coef_const       = data;
            REG_PLANE_OFFSET: plane_cfg.plane_offset     = data[23:0];
            REG_RAW_SCALE:    plane_cfg.raw_scale        = data[15:0];
            REG_MIN_DEPTH:    plane_cfg.min_depth        = data[15:0];
            REG_HEIGHT_THR:   plane_cfg.height_threshold = data[23:0];
            default: ;
        endcase
    endfunction

    // mostly short idle stretches, now and then a long one
    function automatic int idle_cycles();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // small signed coefficient, sometimes full range or an extreme
    function automatic logic [31:0] pick_signed(int bits);
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return $urandom();
        if (pick == 1)
            return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        return 32'(int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    // raw depth: full range, near range, or close to the minimum depth
    function automatic logic [15:0] pick_raw();
        logic [31:0] near_raw;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 16'($urandom_range(0, 65535));
        if (pick < 8 || plane_cfg.raw_scale == 0)
            return 16'($urandom_range(0, 4000));
        near_raw = ((32'(plane_cfg.min_depth) + $urandom_range(0, 2)) << 8)
                   / plane_cfg.raw_scale;
        return (near_raw > 32'hFFFF) ? 16'hFFFF : near_raw[15:0];
    endfunction

    // one register write on the config channel
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        store_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and let every pending word come out
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (height_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_plane(logic [31:0] kx, logic [31:0] ky, logic [31:0] k0,
                             logic [31:0] ofs, logic [31:0] scale,
                             logic [31:0] floor_mm, logic [31:0] thr);
        wait_idle();
        write_reg(REG_COEF_X, kx);
        write_reg(REG_COEF_Y, ky);
        write_reg(REG_COEF_CONST, k0);
        write_reg(REG_PLANE_OFFSET, ofs);
        write_reg(REG_RAW_SCALE, scale);
        write_reg(REG_MIN_DEPTH, floor_mm);
        write_reg(REG_HEIGHT_THR, thr);
        settings_applied++;
    endtask

    // send one pixel word, valid stays up when the next one follows at once
    task automatic send_pixel(logic [15:0] raw, logic [COORD_W-1:0] col,
                              logic [COORD_W-1:0] row);
        int gap;
        gap = (idle_enable && $urandom_range(0, 2) == 0) ? idle_cycles() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_depth_raw <= raw;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(posedge i_clk); while (!o_ready);
        height_q.push_back(predict_height(plane_cfg, raw, col, row));
        pixels_sent++;
    endtask

    // reset defaults: unit scale, min depth 100, threshold 50
    task automatic test_reset_values();
        send_pixel(16'd0, 12'h000, 12'h000);
        send_pixel(16'd100, 12'hFFF, 12'hFFF);
        send_pixel(16'd101, 12'h000, 12'hFFF);
        send_pixel(16'hFFFF, 12'hFFF, 12'h000);
        send_pixel(16'h8000, 12'hAAA, 12'h555);
    endtask

    // depth and height saturation at both signs, dropped unknown index
    task automatic test_register_extremes();
        set_plane(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h007FFFFF,
                  32'h0000FFFF, 32'h00000000, 32'h00FFFFFF);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
        send_pixel(16'd1, 12'h000, 12'h000);
        send_pixel(16'd0, 12'hFFF, 12'hFFF);
        set_plane(32'h80000000, 32'h80000000, 32'h80000000, 32'h00800000,
                  32'h0000FFFF, 32'h00000000, 32'h00000000);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
        send_pixel(16'd1, 12'h000, 12'h000);
        wait_idle();
        write_reg(REG_UNUSED, $urandom());
        send_pixel(16'd2, 12'h800, 12'h001);
    endtask

    // floor rounding of negative products, offset sign flip, fractional scale
    task automatic test_plane_rounding();
        set_plane(32'h0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'd256, 32'd0, 32'd0);
        send_pixel(16'd5, 12'h000, 12'h000);
        set_plane(32'h0, 32'h0, 32'hFF800000, 32'h0, 32'd256, 32'd0, 32'd1);
        send_pixel(16'd3, 12'h000, 12'h000);
        send_pixel(16'd2, 12'h000, 12'h000);
        // junk in the upper data bits of narrow registers
        set_plane(32'h0, 32'h0, 32'h00800000, 32'hA5FFFF9C, 32'h5A000180,
                  32'h00000000, 32'd50);
        send_pixel(16'd3, 12'h000, 12'h000);
        send_pixel(16'd140, 12'h000, 12'h000);
        set_plane(32'h01000000, 32'hFF000000, 32'h0, 32'h0, 32'h00000200,
                  32'd1000, 32'd4103190);
        send_pixel(16'd500, 12'hFFF, 12'h000);
        send_pixel(16'd501, 12'hFFF, 12'h000);
        send_pixel(16'd501, 12'h000, 12'hFFF);
        wait_idle();
        write_reg(REG_RAW_SCALE, 32'h0);
        send_pixel(16'hFFFF, 12'h001, 12'h001);
    endtask

    // random planes, each followed by a burst of random pixels
    task automatic test_random_planes();
        logic [31:0] ofs, scale, floor_mm, thr;
        for (int phase = 0; phase < PHASES; phase++) begin
            idle_enable = (phase % 4 != 2);
            ofs = pick_signed(14);
            ofs[31:24] = $urandom_range(0, 255);
            scale    = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(128, 1024);
            floor_mm = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1500);
            thr      = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3000);
            set_plane(pick_signed(15), pick_signed(15), pick_signed(26), ofs, scale,
                      floor_mm, thr);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, $urandom());
            repeat (PIXELS_PER_PHASE)
                send_pixel(pick_raw(), COORD_W'($urandom()), COORD_W'($urandom()));
        end
        idle_enable = 1'b1;
    endtask

    // receiver backpressure
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_enable && i_ready && $urandom_range(0, 1) == 1) begin
            i_ready    <= 1'b0;
            ready_hold <= idle_cycles() - 1;
        end else begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 12);
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (height_q.size() == 0) begin
                $display("%0t: unexpected word height %0d obstacle %0b valid %0b",
                         $time, o_height_mm, o_obstacle, o_depth_valid);
                mismatches++;
            end else begin
                expected_word = height_q.pop_front();
                words_checked++;
                if (o_height_mm !== expected_word.height_mm) begin
                    $display("%0t: height_mm expected %0d actual %0d",
                             $time, expected_word.height_mm, o_height_mm);
                    mismatches++;
                end
                if (o_obstacle !== expected_word.obstacle) begin
                    $display("%0t: obstacle expected %0b actual %0b",
                             $time, expected_word.obstacle, o_obstacle);
                    mismatches++;
                end
                if (o_depth_valid !== expected_word.depth_valid) begin
                    $display("%0t: depth_valid expected %0b actual %0b",
                             $time, expected_word.depth_valid, o_depth_valid);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_depth_raw      = '0;
        i_pixel_col      = '0;
        i_pixel_row      = '0;
        i_ready          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        idle_enable      = 1'b1;
        ready_hold       = 0;
        idle_count       = 0;
        mismatches       = 0;
        pixels_sent      = 0;
        words_checked    = 0;
        settings_applied = 1;
        plane_cfg.coef_x           = RST_COEF_X;
        plane_cfg.coef_y           = RST_COEF_Y;
        plane_cfg.coef_const       = RST_COEF_CONST;
        plane_cfg.plane_offset     = RST_PLANE_OFFSET;
        plane_cfg.raw_scale        = RST_RAW_SCALE;
        plane_cfg.min_depth        = RST_MIN_DEPTH;
        plane_cfg.height_threshold = RST_HEIGHT_THR;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_extremes();
        test_plane_rounding();
        test_random_planes();

        // drain and give stray words time to show up
        wait_idle();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (height_q.size() != 0) begin
            $display("%0t: %0d predicted words never came out", $time, height_q.size());
            mismatches += height_q.size();
        end
        $display("Checked %0d height words from %0d pixels over %0d plane settings,",
                 words_checked, pixels_sent, settings_applied);
        $display("covering invalid depth, depth and height saturation and floor rounding.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
